[rtl/ctas_pkg.sv]
// Shared types, constants and the arctangent table for the contour turning angle statistics block.
// It depends on nothing. Every other file in rtl but ctas_fifo uses it through scoped names.
package ctas_pkg;

    // Widths of the configuration and result fields.
    localparam int LAG_BITS    = 7;
    localparam int ANGLE_BITS  = 16;
    localparam int MEAN_BITS   = 16;
    localparam int VAR_BITS    = 31;
    localparam int STATUS_BITS = 2;

    localparam logic [LAG_BITS-1:0]   LAG_RESET = 7'd5;
    localparam logic [ANGLE_BITS-1:0] HALF_TURN = 16'h8000;

    // Vectoring iterations of the arctangent unit.
    localparam int CORDIC_STEPS = 15;
    localparam int STEP_BITS    = 4;

    // Result status codes.
    localparam logic [STATUS_BITS-1:0] STATUS_OK  = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_FEW = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_OVF = 2'd2;

    // How the back end treats a queued point.
    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_ANGLE,
        KIND_IGNORE
    } t_kind;

    // Control part of one queue entry.
    typedef struct packed {
        t_kind kind;
        logic  last;
        logic  ovf;
    } t_job_ctl;

    localparam int JOB_CTL_BITS = 4;

    // Handoff from the arctangent unit to the back end.
    typedef struct packed {
        logic                  done;
        logic [ANGLE_BITS-1:0] angle;
    } t_cordic_res;

    // Back end sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_FINISH,
        ST_MUL_NS2,
        ST_MUL_S1S1,
        ST_MUL_NN,
        ST_DIV_VAR,
        ST_DIV_MEAN,
        ST_RESULT
    } t_back_state;

    // Rounded atan(2^-i) in binary angle units, 65536 per turn.
    function automatic logic [ANGLE_BITS-1:0] atan_step(input logic [STEP_BITS-1:0] i);
        logic [ANGLE_BITS-1:0] v;
        case (i)
            4'd0:    v = 16'd8192;
            4'd1:    v = 16'd4836;
            4'd2:    v = 16'd2555;
            4'd3:    v = 16'd1297;
            4'd4:    v = 16'd651;
            4'd5:    v = 16'd326;
            4'd6:    v = 16'd163;
            4'd7:    v = 16'd81;
            4'd8:    v = 16'd41;
            4'd9:    v = 16'd20;
            4'd10:   v = 16'd10;
            4'd11:   v = 16'd5;
            4'd12:   v = 16'd3;
            4'd13:   v = 16'd1;
            4'd14:   v = 16'd1;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

[rtl/ctas_if.sv]
// Channel interfaces of the contour turning angle statistics block: points, results, configuration.
// Depends on ctas_pkg for the field widths.

// Point channel, one contour point per transfer.
interface ctas_point_if #(
    parameter int COORD_BITS = 12
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] point_x;
    logic [COORD_BITS-1:0] point_y;
    logic                  last_point;

    modport source (output valid, output point_x, output point_y, output last_point,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input last_point,
                    output ready);
endinterface

// Result channel, one statistics record per contour.
interface ctas_result_if;
    logic                              valid;
    logic                              ready;
    logic [ctas_pkg::MEAN_BITS-1:0]    mean_turn;
    logic [ctas_pkg::VAR_BITS-1:0]     turn_variance;
    logic [ctas_pkg::STATUS_BITS-1:0]  status;

    modport source (output valid, output mean_turn, output turn_variance, output status,
                    input ready);
    modport sink   (input valid, input mean_turn, input turn_variance, input status,
                    output ready);
endinterface

// Configuration write channel for the lag register.
interface ctas_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [ctas_pkg::LAG_BITS-1:0] lag;

    modport source (output valid, output lag, input ready);
    modport sink   (input valid, input lag, output ready);
endinterface

[rtl/contour_turning_angle_stats_core.sv]
// Top level of the contour turning angle statistics block.
// Depends on ctas_pkg, ctas_if, ctas_front, ctas_fifo, ctas_cordic and ctas_back.
//
// Usage: points of one contour arrive on i_point, one per transfer, with last_point set on
// the final one. i_cfg writes the lag register (reset value 5) and is always ready; write it
// only while the block is idle. Each last point yields one transfer on o_result with the
// mean and population variance of the wrapped tangent angle changes and a status code.
// Timing: the front end takes a point every cycle into a four-entry job queue while the queue
// is not full. The back end pops no further point while a point with a tangent goes through
// the 15 iterations of the shared arctangent unit. On the last point the statistics are formed
// by the bit-serial multiply and divide unit, multiplies first and then the variance and mean
// divides, before the result is registered. Reset clears all contour state and the queue; the
// window memory needs no clearing. When o_result stalls, the finished result waits in its
// register, further points are still taken until the queue fills, and the next result waits
// for the register.
module contour_turning_angle_stats_core #(
    parameter int MAX_LAG    = 64,
    parameter int MAX_POINTS = 65536,
    parameter int COORD_BITS = 12
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    ctas_cfg_if.sink             i_cfg,
    ctas_point_if.sink           i_point,
    ctas_result_if.source        o_result
);

    localparam int QUEUE_DEPTH = 4;
    localparam int QW = ctas_pkg::JOB_CTL_BITS + 2 * (COORD_BITS + 1);

    logic [ctas_pkg::LAG_BITS-1:0] r_lag;

    logic                       push, full, pop, empty, cordic_start;
    ctas_pkg::t_job_ctl         front_ctl, back_ctl;
    logic signed [COORD_BITS:0] front_dx, front_dy, back_dx, back_dy;
    logic [QW-1:0]              q_in, q_out;
    ctas_pkg::t_cordic_res      cordic_res;

    // Lag register write transfer.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lag <= ctas_pkg::LAG_RESET;
        end else if (i_cfg.valid) begin
            r_lag <= i_cfg.lag;
        end
    end

    ctas_front #(
        .MAX_LAG    (MAX_LAG),
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_lag        (r_lag),
        .i_valid      (i_point.valid),
        .o_ready      (i_point.ready),
        .i_point_x    (i_point.point_x),
        .i_point_y    (i_point.point_y),
        .i_last_point (i_point.last_point),
        .o_push       (push),
        .i_full       (full),
        .o_ctl        (front_ctl),
        .o_dx         (front_dx),
        .o_dy         (front_dy)
    );

    // Job queue entry: control, then the difference vector.
    assign q_in = {front_ctl, front_dx, front_dy};
    assign {back_ctl, back_dx, back_dy} = q_out;

    ctas_fifo #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (q_out),
        .o_empty (empty)
    );

    ctas_cordic #(
        .COORD_BITS (COORD_BITS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cordic_start),
        .i_dx    (back_dx),
        .i_dy    (back_dy),
        .o_res   (cordic_res)
    );

    ctas_back #(
        .MAX_POINTS (MAX_POINTS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_empty         (empty),
        .i_ctl           (back_ctl),
        .o_pop           (pop),
        .o_cordic_start  (cordic_start),
        .i_cordic        (cordic_res),
        .o_valid         (o_result.valid),
        .i_ready         (o_result.ready),
        .o_mean_turn     (o_result.mean_turn),
        .o_turn_variance (o_result.turn_variance),
        .o_status        (o_result.status)
    );

endmodule

[rtl/ctas_front.sv]
// Front end: point window memory, point counting and classification of each point.
// Depends on ctas_pkg; feeds difference vectors into the job queue.
module ctas_front #(
    parameter int MAX_LAG    = 64,
    parameter int MAX_POINTS = 65536,
    parameter int COORD_BITS = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [ctas_pkg::LAG_BITS-1:0] i_lag,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [COORD_BITS-1:0]         i_point_x,
    input  logic [COORD_BITS-1:0]         i_point_y,
    input  logic                          i_last_point,
    output logic                          o_push,
    input  logic                          i_full,
    output ctas_pkg::t_job_ctl            o_ctl,
    output logic signed [COORD_BITS:0]    o_dx,
    output logic signed [COORD_BITS:0]    o_dy
);

    localparam int DEPTH  = MAX_LAG + 1;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int LW0    = $clog2(MAX_LAG + 1);
    localparam int LW     = (LW0 > ctas_pkg::LAG_BITS) ? LW0 : ctas_pkg::LAG_BITS;
    localparam int AW     = ((PTR_W > LW) ? PTR_W : LW) + 1;
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int EW     = 2 * COORD_BITS;

    logic [EW-1:0]       r_win [DEPTH];
    logic [EW-1:0]       r_rd;
    logic [PTR_W-1:0]    r_wr, n_wr;
    logic [CNT_W-1:0]    r_count, n_count;
    logic                r_ovf, n_ovf;
    logic                r_s1_valid;
    ctas_pkg::t_job_ctl  r_s1_ctl, n_ctl;
    logic [COORD_BITS-1:0] r_s1_x, r_s1_y;
    logic                r_s1_zero;

    logic                accept;
    logic                we;
    logic [LW-1:0]       lag_eff;
    logic [AW-1:0]       wr_ext, l_ext, rd_ext;
    logic [PTR_W-1:0]    rd_idx;
    logic [COORD_BITS-1:0] old_x, old_y;

    assign o_ready = !r_s1_valid || !i_full;
    assign o_push  = r_s1_valid && !i_full;
    assign accept  = i_valid && o_ready;

    // Lag above MAX_LAG is clamped to MAX_LAG.
    always_comb begin
        if (32'(i_lag) > 32'(MAX_LAG)) begin
            lag_eff = LW'(MAX_LAG);
        end else begin
            lag_eff = LW'(i_lag);
        end
    end

    // Window slot of the point lag places back, modulo the window depth.
    always_comb begin
        wr_ext = AW'(r_wr);
        l_ext  = AW'(lag_eff);
        if (wr_ext >= l_ext) begin
            rd_ext = wr_ext - l_ext;
        end else begin
            rd_ext = wr_ext + AW'(DEPTH) - l_ext;
        end
        rd_idx = rd_ext[PTR_W-1:0];
    end

    // Classify the point and advance the contour counters.
    always_comb begin
        n_ovf      = r_ovf;
        n_count    = r_count;
        n_wr       = r_wr;
        we         = 1'b0;
        n_ctl.kind = ctas_pkg::KIND_IGNORE;
        n_ctl.last = i_last_point;
        if (32'(r_count) >= 32'(MAX_POINTS)) begin
            n_ovf = 1'b1;
        end else if (!r_ovf) begin
            we = accept;
            if (32'(r_count) >= 32'(lag_eff)) begin
                n_ctl.kind = ctas_pkg::KIND_ANGLE;
            end else begin
                n_ctl.kind = ctas_pkg::KIND_NONE;
            end
            n_count = r_count + CNT_W'(1);
            n_wr    = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        n_ctl.ovf = n_ovf;
        if (i_last_point) begin
            n_ovf   = 1'b0;
            n_count = '0;
            n_wr    = '0;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr       <= '0;
            r_count    <= '0;
            r_ovf      <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_wr       <= n_wr;
                r_count    <= n_count;
                r_ovf      <= n_ovf;
                r_s1_valid <= 1'b1;
            end else if (o_push) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // Point window memory and the staged point.
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_win[r_wr] <= {i_point_x, i_point_y};
        end
        if (accept) begin
            r_rd      <= r_win[rd_idx];
            r_s1_ctl  <= n_ctl;
            r_s1_x    <= i_point_x;
            r_s1_y    <= i_point_y;
            r_s1_zero <= (lag_eff == '0);
        end
    end

    // Difference vector; a lag of zero gives the zero vector.
    assign old_x = r_rd[EW-1:COORD_BITS];
    assign old_y = r_rd[COORD_BITS-1:0];
    assign o_ctl = r_s1_ctl;

    always_comb begin
        if (r_s1_zero) begin
            o_dx = '0;
            o_dy = '0;
        end else begin
            o_dx = $signed({1'b0, r_s1_x}) - $signed({1'b0, old_x});
            o_dy = $signed({1'b0, r_s1_y}) - $signed({1'b0, old_y});
        end
    end

endmodule

[rtl/ctas_fifo.sv]
// Short job queue between the front end and the back end.
// Depends on ctas_pkg only through the entry width chosen by the instantiating module.
module ctas_fifo #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = AW + 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("queue fill level above its depth");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue popped while empty");

endmodule

[rtl/ctas_cordic.sv]
// Iterative vectoring arctangent unit, one rotation step per cycle.
// Depends on ctas_pkg for the angle table and the result struct.
module ctas_cordic #(
    parameter int COORD_BITS = 12
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic signed [COORD_BITS:0] i_dx,
    input  logic signed [COORD_BITS:0] i_dy,
    output ctas_pkg::t_cordic_res      o_res
);

    localparam int CW = COORD_BITS + 20;

    logic                              r_busy;
    logic                              r_done;
    logic                              r_zero;
    logic [ctas_pkg::STEP_BITS-1:0]    r_i;
    logic signed [CW-1:0]              r_x, r_y;
    logic [ctas_pkg::ANGLE_BITS-1:0]   r_z;

    logic signed [CW-1:0]              x0, y0, xs, ys;
    logic [ctas_pkg::ANGLE_BITS-1:0]   t;

    // Inputs scaled by 65536.
    assign x0 = {{(CW - COORD_BITS - 17){i_dx[COORD_BITS]}}, i_dx, 16'h0000};
    assign y0 = {{(CW - COORD_BITS - 17){i_dy[COORD_BITS]}}, i_dy, 16'h0000};
    assign xs = r_x >>> r_i;
    assign ys = r_y >>> r_i;
    assign t  = ctas_pkg::atan_step(r_i);

    // Control: one step per cycle until the last iteration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_i    <= '0;
            end else if (r_busy) begin
                if (r_i == ctas_pkg::STEP_BITS'(ctas_pkg::CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_i <= r_i + ctas_pkg::STEP_BITS'(1);
            end
        end
    end

    // Rotation datapath; a vector in the left half plane is turned by half a turn first.
    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_zero <= (i_dx == '0) && (i_dy == '0);
            if (i_dx < 0) begin
                r_x <= -x0;
                r_y <= -y0;
                r_z <= ctas_pkg::HALF_TURN;
            end else begin
                r_x <= x0;
                r_y <= y0;
                r_z <= '0;
            end
        end else if (r_busy) begin
            if (r_y > 0) begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + t;
            end else begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - t;
            end
        end
    end

    assign o_res.done  = r_done;
    assign o_res.angle = r_zero ? '0 : r_z;

endmodule

[rtl/ctas_back.sv]
// Back end: turning angle sums, the end of contour statistics sequencer and the result register.
// Depends on ctas_pkg and drives the shared arctangent unit.
module ctas_back #(
    parameter int MAX_POINTS = 65536
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_empty,
    input  ctas_pkg::t_job_ctl               i_ctl,
    output logic                             o_pop,
    output logic                             o_cordic_start,
    input  ctas_pkg::t_cordic_res            i_cordic,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [ctas_pkg::MEAN_BITS-1:0]   o_mean_turn,
    output logic [ctas_pkg::VAR_BITS-1:0]    o_turn_variance,
    output logic [ctas_pkg::STATUS_BITS-1:0] o_status
);

    localparam int NW  = $clog2(MAX_POINTS + 1);
    localparam int S1W = NW + 16;
    localparam int S2W = NW + 31;
    localparam int PW  = NW + S2W;
    localparam int CTW = $clog2(PW);
    localparam int AB  = ctas_pkg::ANGLE_BITS;

    ctas_pkg::t_back_state r_state, n_state;

    logic                 r_last, r_ovf, r_prev_valid;
    logic [AB-1:0]        r_prev_angle;
    logic [NW-1:0]        r_n;
    logic [S1W-1:0]       r_s1;
    logic [S2W-1:0]       r_s2;
    logic [PW-1:0]        r_opa, r_opb, r_acc, r_m1;
    logic [PW:0]          r_rem;
    logic [CTW-1:0]       r_cnt;
    logic [ctas_pkg::MEAN_BITS-1:0]   r_mean;
    logic [ctas_pkg::VAR_BITS-1:0]    r_var;
    logic [ctas_pkg::STATUS_BITS-1:0] r_stat;
    logic                 r_out_valid;
    logic [ctas_pkg::MEAN_BITS-1:0]   r_out_mean;
    logic [ctas_pkg::VAR_BITS-1:0]    r_out_var;
    logic [ctas_pkg::STATUS_BITS-1:0] r_out_status;

    logic [PW-1:0]        mul_acc, div_acc;
    logic [PW:0]          rem_sh, div_rem;
    logic                 div_ge;
    logic                 step_end;
    logic                 out_free;
    logic [AB-1:0]        d, w;
    logic [2*AB-1:0]      ww;

    // Shift-add multiply and restoring divide, one bit per cycle.
    assign mul_acc  = (r_acc << 1) + (r_opb[PW-1] ? r_opa : '0);
    assign rem_sh   = {r_rem[PW-1:0], r_opa[PW-1]};
    assign div_ge   = rem_sh >= {1'b0, r_opb};
    assign div_rem  = div_ge ? rem_sh - {1'b0, r_opb} : rem_sh;
    assign div_acc  = {r_acc[PW-2:0], div_ge};
    assign step_end = (r_cnt == CTW'(PW - 1));
    assign out_free = !r_out_valid || i_ready;

    // Wrapped change between neighbouring tangent angles.
    assign d  = i_cordic.angle - r_prev_angle;
    assign w  = (d <= ctas_pkg::HALF_TURN) ? d : AB'(0) - d;
    assign ww = w * w;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ctas_pkg::ST_IDLE: begin
                if (!i_empty) begin
                    if (i_ctl.kind == ctas_pkg::KIND_ANGLE) begin
                        n_state = ctas_pkg::ST_CORDIC;
                    end else if (i_ctl.last) begin
                        n_state = ctas_pkg::ST_FINISH;
                    end
                end
            end
            ctas_pkg::ST_CORDIC: begin
                if (i_cordic.done) begin
                    n_state = r_last ? ctas_pkg::ST_FINISH : ctas_pkg::ST_IDLE;
                end
            end
            ctas_pkg::ST_FINISH: begin
                if (r_ovf || r_n == '0) begin
                    n_state = ctas_pkg::ST_RESULT;
                end else begin
                    n_state = ctas_pkg::ST_MUL_NS2;
                end
            end
            ctas_pkg::ST_MUL_NS2:  if (step_end) n_state = ctas_pkg::ST_MUL_S1S1;
            ctas_pkg::ST_MUL_S1S1: if (step_end) n_state = ctas_pkg::ST_MUL_NN;
            ctas_pkg::ST_MUL_NN:   if (step_end) n_state = ctas_pkg::ST_DIV_VAR;
            ctas_pkg::ST_DIV_VAR:  if (step_end) n_state = ctas_pkg::ST_DIV_MEAN;
            ctas_pkg::ST_DIV_MEAN: if (step_end) n_state = ctas_pkg::ST_RESULT;
            ctas_pkg::ST_RESULT: begin
                if (out_free) begin
                    n_state = ctas_pkg::ST_IDLE;
                end
            end
            default: n_state = ctas_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        o_pop          = (r_state == ctas_pkg::ST_IDLE) && !i_empty;
        o_cordic_start = o_pop && (i_ctl.kind == ctas_pkg::KIND_ANGLE);
    end

    // State, contour sums and the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ctas_pkg::ST_IDLE;
            r_prev_valid <= 1'b0;
            r_prev_angle <= '0;
            r_n          <= '0;
            r_s1         <= '0;
            r_s2         <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop && i_ctl.kind == ctas_pkg::KIND_NONE) begin
                r_prev_valid <= 1'b0;
            end
            if (r_state == ctas_pkg::ST_CORDIC && i_cordic.done) begin
                if (r_prev_valid) begin
                    r_s1 <= r_s1 + S1W'(w);
                    r_s2 <= r_s2 + S2W'(ww);
                    r_n  <= r_n + NW'(1);
                end
                r_prev_angle <= i_cordic.angle;
                r_prev_valid <= 1'b1;
            end
            if (r_state == ctas_pkg::ST_RESULT && out_free) begin
                r_out_valid  <= 1'b1;
                r_prev_valid <= 1'b0;
                r_prev_angle <= '0;
                r_n          <= '0;
                r_s1         <= '0;
                r_s2         <= '0;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Arithmetic sequencer datapath.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_last <= i_ctl.last;
            r_ovf  <= i_ctl.ovf;
        end
        r_cnt <= step_end ? '0 : r_cnt + CTW'(1);
        case (r_state)
            ctas_pkg::ST_FINISH: begin
                r_mean <= '0;
                r_var  <= '0;
                if (r_ovf) begin
                    r_stat <= ctas_pkg::STATUS_OVF;
                end else if (r_n == '0) begin
                    r_stat <= ctas_pkg::STATUS_FEW;
                end else begin
                    r_stat <= ctas_pkg::STATUS_OK;
                end
                r_opa <= PW'(r_s2);
                r_opb <= PW'(r_n);
                r_acc <= '0;
                r_cnt <= '0;
            end
            ctas_pkg::ST_MUL_NS2, ctas_pkg::ST_MUL_S1S1, ctas_pkg::ST_MUL_NN: begin
                r_acc <= mul_acc;
                r_opb <= r_opb << 1;
                if (step_end) begin
                    r_acc <= '0;
                    r_rem <= '0;
                    if (r_state == ctas_pkg::ST_MUL_NS2) begin
                        r_m1  <= mul_acc;
                        r_opa <= PW'(r_s1);
                        r_opb <= PW'(r_s1);
                    end else if (r_state == ctas_pkg::ST_MUL_S1S1) begin
                        r_m1  <= r_m1 - mul_acc;
                        r_opa <= PW'(r_n);
                        r_opb <= PW'(r_n);
                    end else begin
                        r_opa <= r_m1;
                        r_opb <= mul_acc;
                    end
                end
            end
            ctas_pkg::ST_DIV_VAR, ctas_pkg::ST_DIV_MEAN: begin
                r_acc <= div_acc;
                r_rem <= div_rem;
                r_opa <= r_opa << 1;
                if (step_end) begin
                    r_acc <= '0;
                    r_rem <= '0;
                    if (r_state == ctas_pkg::ST_DIV_VAR) begin
                        r_var <= div_acc[ctas_pkg::VAR_BITS-1:0];
                        r_opa <= PW'(r_s1);
                        r_opb <= PW'(r_n);
                    end else begin
                        r_mean <= div_acc[ctas_pkg::MEAN_BITS-1:0];
                    end
                end
            end
            ctas_pkg::ST_RESULT: begin
                if (out_free) begin
                    r_out_mean   <= r_mean;
                    r_out_var    <= r_var;
                    r_out_status <= r_stat;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_valid         = r_out_valid;
    assign o_mean_turn     = r_out_mean;
    assign o_turn_variance = r_out_var;
    assign o_status        = r_out_status;

    a_error_zeros: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_status != ctas_pkg::STATUS_OK
            |-> r_out_mean == '0 && r_out_var == '0)
        else $error("error result carries nonzero statistics");

    a_mean_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_mean <= ctas_pkg::HALF_TURN)
        else $error("mean turning angle above half a turn");

    a_cordic_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cordic.done |-> r_state == ctas_pkg::ST_CORDIC)
        else $error("arctangent finished while the back end was not waiting");

endmodule

[sim/testbench.sv]
// Self-checking testbench for contour_turning_angle_stats_core: drives contours of points and
// lag writes, predicts each statistics record and compares it with what the block returns.
// Depends on ctas_pkg, the ctas_if interfaces and the RTL of the block.
`timescale 1ns / 100ps

// Tracks contour state, predicts statistics records and checks the returned ones.
class turn_stats_board;
    localparam int WIN_SLOTS = 65;
    localparam int MAX_PTS   = 65536;

    bit [15:0]               atan_lut [15];
    bit [23:0]               window [WIN_SLOTS];
    bit [6:0]                lag_reg;
    bit [15:0]               last_angle;
    bit                      last_angle_ok;
    int unsigned             pts_seen;
    longint unsigned         sum_turn;
    longint unsigned         sum_turn_sq;
    int unsigned             turn_count;
    bit                      count_ovf;
    bit [15:0]               exp_mean [$];
    bit [30:0]               exp_var [$];
    bit [1:0]                exp_status [$];
    int                      errors;
    int                      records;
    int                      status_seen [3];

    function new();
        atan_lut = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1};
        lag_reg = ctas_pkg::LAG_RESET;
        errors = 0;
        records = 0;
        clear_contour();
    endfunction

    function void clear_contour();
        last_angle = '0;
        last_angle_ok = 0;
        pts_seen = 0;
        sum_turn = 0;
        sum_turn_sq = 0;
        turn_count = 0;
        count_ovf = 0;
    endfunction

    function void set_lag(bit [6:0] v);
        lag_reg = v;
    endfunction

    // Vectoring arctangent with floor shifts, 65536 units per turn.
    function bit [15:0] tangent_angle(longint dx, longint dy);
        longint x, y, xs, ys;
        int unsigned z;
        if (dx == 0 && dy == 0) begin
            return 16'd0;
        end
        x = dx * 65536;
        y = dy * 65536;
        z = 0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 32768;
        end
        for (int i = 0; i < 15; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x += ys;
                y -= xs;
                z += atan_lut[i];
            end else begin
                x -= ys;
                y += xs;
                z -= atan_lut[i];
            end
        end
        return z[15:0];
    endfunction

    // Updates the contour sums for an accepted point; a last point queues one record.
    function void note_point(bit [11:0] px, bit [11:0] py, bit last);
        int unsigned span, k;
        bit [23:0] old;
        bit [15:0] ang, d;
        int unsigned w;
        longint unsigned n, num;
        span = (lag_reg > 64) ? 64 : lag_reg;
        if (pts_seen >= MAX_PTS) begin
            count_ovf = 1;
        end else if (!count_ovf) begin
            k = pts_seen;
            window[k % WIN_SLOTS] = {px, py};
            if (k >= span) begin
                old = window[(k - span) % WIN_SLOTS];
                ang = tangent_angle(longint'(px) - longint'(old[23:12]),
                                    longint'(py) - longint'(old[11:0]));
                if (last_angle_ok) begin
                    d = ang - last_angle;
                    w = (d <= 16'h8000) ? d : 65536 - d;
                    sum_turn += w;
                    sum_turn_sq += longint'(w) * w;
                    turn_count++;
                end
                last_angle = ang;
                last_angle_ok = 1;
            end else begin
                last_angle_ok = 0;
            end
            pts_seen = k + 1;
        end
        if (!last) begin
            return;
        end
        if (count_ovf) begin
            exp_mean.push_back('0);
            exp_var.push_back('0);
            exp_status.push_back(ctas_pkg::STATUS_OVF);
        end else if (turn_count < 1) begin
            exp_mean.push_back('0);
            exp_var.push_back('0);
            exp_status.push_back(ctas_pkg::STATUS_FEW);
        end else begin
            n = turn_count;
            num = n * sum_turn_sq - sum_turn * sum_turn;
            exp_mean.push_back(16'(sum_turn / n));
            exp_var.push_back(31'(num / (n * n)));
            exp_status.push_back(ctas_pkg::STATUS_OK);
        end
        clear_contour();
    endfunction

    function int pending();
        return exp_status.size();
    endfunction

    // Compares one returned record with the oldest prediction.
    function void check_record(bit [15:0] mean, bit [30:0] variance, bit [1:0] status);
        bit [15:0] em;
        bit [30:0] ev;
        bit [1:0]  es;
        if (exp_status.size() == 0) begin
            $display("%0t: unexpected record mean=%0d var=%0d status=%0d",
                     $time, mean, variance, status);
            errors++;
            return;
        end
        em = exp_mean.pop_front();
        ev = exp_var.pop_front();
        es = exp_status.pop_front();
        records++;
        if (status < 3) status_seen[status]++;
        if (mean !== em) begin
            $display("%0t: mean_turn expected %0d actual %0d", $time, em, mean);
            errors++;
        end
        if (variance !== ev) begin
            $display("%0t: turn_variance expected %0d actual %0d", $time, ev, variance);
            errors++;
        end
        if (status !== es) begin
            $display("%0t: status expected %0d actual %0d", $time, es, status);
            errors++;
        end
    endfunction
endclass

module testbench;
    localparam int  SETTLE_CYCLES = 500;
    localparam int  HOLD_CYCLES   = 3000;
    localparam longint CYCLE_LIMIT = 1_000_000;

    logic i_clk;
    logic i_rst_n;

    ctas_point_if #(.COORD_BITS(12)) pt ();
    ctas_result_if                   res ();
    ctas_cfg_if                      cfg ();

    contour_turning_angle_stats_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_point  (pt),
        .o_result (res)
    );

    turn_stats_board board;
    bit     no_idle;
    bit     hold_request;
    longint cycles;
    int     points_sent;
    int     walk_x, walk_y;

    // Clock, period 10 ns.
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("testbench NOT OK");
            $finish;
        end
    end

    // Result side: random stalls, one long hold-off on request, and checking.
    always @(posedge i_clk) begin
        int hold_left;
        if (!i_rst_n) begin
            res.ready <= 1'b0;
            hold_left = 0;
        end else begin
            if (res.valid && res.ready) begin
                board.check_record(res.mean_turn, res.turn_variance, res.status);
            end
            if (hold_request) begin
                hold_request = 0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res.ready <= 1'b0;
            end else begin
                res.ready <= no_idle || ($urandom_range(99) >= 16);
            end
        end
    end

    // Offers one point and waits for its transfer; may idle first.
    task automatic send_point(input bit [11:0] px, input bit [11:0] py, input bit last);
        if (!no_idle && $urandom_range(99) < 16) begin
            pt.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        pt.valid      <= 1'b1;
        pt.point_x    <= px;
        pt.point_y    <= py;
        pt.last_point <= last;
        do @(posedge i_clk); while (!pt.ready);
        board.note_point(px, py, last);
        points_sent++;
    endtask

    // Waits until every predicted record has come back.
    task automatic drain_records();
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    // Waits until all records are back and the block has settled, then writes the lag.
    task automatic write_lag(input bit [6:0] v);
        pt.valid <= 1'b0;
        drain_records();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg.valid <= 1'b1;
        cfg.lag   <= v;
        do @(posedge i_clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        board.set_lag(v);
    endtask

    // Contour as a random walk; a share of points jump anywhere in the plane.
    task automatic send_contour(input int len, input int stride);
        int nx, ny;
        walk_x = $urandom_range(4095);
        walk_y = $urandom_range(4095);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(99) < 15) begin
                nx = $urandom_range(4095);
                ny = $urandom_range(4095);
            end else begin
                nx = walk_x + $urandom_range(2 * stride) - stride;
                ny = walk_y + $urandom_range(2 * stride) - stride;
            end
            walk_x = (nx < 0) ? 0 : (nx > 4095) ? 4095 : nx;
            walk_y = (ny < 0) ? 0 : (ny > 4095) ? 4095 : ny;
            send_point(walk_x[11:0], walk_y[11:0], i == len - 1);
        end
    endtask

    initial begin
        bit [6:0] lag_v;
        board = new();
        cycles = 0;
        points_sent = 0;
        no_idle = 0;
        hold_request = 0;
        i_rst_n = 1'b0;
        pt.valid = 1'b0;
        pt.point_x = '0;
        pt.point_y = '0;
        pt.last_point = 1'b0;
        cfg.valid = 1'b0;
        cfg.lag = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset lag, corner points, then a lone point with too few changes.
        send_point(12'd0, 12'd0, 0);
        send_point(12'd4095, 12'd0, 0);
        send_point(12'd4095, 12'd4095, 0);
        send_point(12'd0, 12'd4095, 0);
        send_point(12'd0, 12'd0, 0);
        send_point(12'd4095, 12'd4095, 0);
        send_point(12'd4095, 12'd0, 1);
        send_point(12'd2048, 12'd2048, 1);

        // Lag zero: every vector is zero, so every change is zero.
        write_lag(7'd0);
        send_point(12'd100, 12'd200, 0);
        send_point(12'd4095, 12'd0, 1);

        // Lag one around a square, with reversals and the half-turn change.
        write_lag(7'd1);
        send_point(12'd0, 12'd0, 0);
        send_point(12'd4095, 12'd0, 0);
        send_point(12'd0, 12'd0, 0);
        send_point(12'd0, 12'd4095, 0);
        // Lag changed in the middle of a contour.
        write_lag(7'd2);
        send_point(12'd1, 12'd4095, 0);
        send_point(12'd4095, 12'd4095, 1);

        // Largest lag, and a lag above the largest, both too short here.
        write_lag(7'd64);
        send_point(12'd10, 12'd10, 0);
        send_point(12'd20, 12'd30, 1);
        write_lag(7'd127);
        send_point(12'd4095, 12'd1, 0);
        send_point(12'd3, 12'd4094, 1);

        // Random phases, each with its own lag.
        for (int phase = 0; points_sent < 820; phase++) begin
            case ($urandom_range(5))
                0: lag_v = 7'd0;
                1: lag_v = 7'd64;
                2: lag_v = 7'd65 + 7'($urandom_range(62));
                default: lag_v = 7'($urandom_range(1, 8));
            endcase
            write_lag(lag_v);
            no_idle = (phase == 4);
            if (phase == 2) begin
                hold_request = 1;
            end
            for (int c = 0; c < 6; c++) begin
                if (phase == 2) begin
                    send_contour($urandom_range(1, 3), 40);
                end else if (lag_v >= 64 && $urandom_range(3) == 0) begin
                    send_contour($urandom_range(64, 90), 200);
                end else begin
                    send_contour($urandom_range(1, 30), $urandom_range(1, 300));
                end
            end
        end
        pt.valid <= 1'b0;

        drain_records();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("%0d points in directed and random contours over a range of lags",
                 points_sent);
        $display("%0d records checked: %0d ok, %0d too few points",
                 board.records, board.status_seen[0], board.status_seen[1]);
        if (board.errors == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end
endmodule

[files.f]
rtl/ctas_pkg.sv
rtl/ctas_if.sv
rtl/ctas_front.sv
rtl/ctas_fifo.sv
rtl/ctas_cordic.sv
rtl/ctas_back.sv
rtl/contour_turning_angle_stats_core.sv
sim/testbench.sv
